>>> rtl/form_urlencoded_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the form-urlencoded decoder
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FORM_URLENCODED_DECODER_UNIT_ASSERT_SVH
`define FORM_URLENCODED_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define FUD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FUD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fud_pkg.sv
// ----------------------------------------------------------------------------
// fud_pkg
// Shared types, character codes and helpers of the form-urlencoded decoder.
// ----------------------------------------------------------------------------
package fud_pkg;

  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // results caused by one input byte: up to three, terminator only last
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic            term;
    logic            is_value;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    hex_nib = v[3:0];
  endfunction

endpackage

>>> rtl/fud_in_if.sv
// ----------------------------------------------------------------------------
// fud_in_if
// Input channel: one raw byte or an end-of-string mark per transfer.
// ----------------------------------------------------------------------------
interface fud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

>>> rtl/fud_out_if.sv
// ----------------------------------------------------------------------------
// fud_out_if
// Result channel: one decoded byte or token terminator per transfer.
// ----------------------------------------------------------------------------
interface fud_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       token_end;
  logic       is_value;
  logic       last_of_run;

  modport source (output valid, output out_byte, output token_end, output is_value,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input token_end, input is_value,
                  input last_of_run, output ready);
endinterface

>>> rtl/form_urlencoded_decoder_unit.sv
// ----------------------------------------------------------------------------
// form_urlencoded_decoder_unit
// Form-urlencoded stream decoder: raw bytes in, decoded bytes and token
// terminators out.
// ----------------------------------------------------------------------------
// Takes one raw byte (or an end-of-string mark) per transfer and emits zero to
// three results for it: '+' decodes to space, '%' with two hex digits to the
// byte they spell, '=' and '&' end the token with a terminator, and an end
// mark flushes a pending escape literally and terminates the token. Input is
// accepted every cycle while the four-run queue has room; results leave one
// per cycle while the output is ready, so the sustained rate is set by the
// result count, the output register being the single point where results
// are serialized. An accepted byte's run is registered in the queue and then
// in the output register before its first result appears.
module form_urlencoded_decoder_unit import fud_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  fud_in_if.sink    in_ch,
  fud_out_if.source out_ch
);

  logic    push, pop;
  run_t    push_run, head;
  q_stat_t q_stat;

  fud_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_run (push_run)
  );

  fud_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  fud_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

>>> rtl/fud_front.sv
// ----------------------------------------------------------------------------
// fud_front
// Accepts raw bytes, tracks escape state and token parity, and packs the
// results each byte causes into one run for the queue.
// ----------------------------------------------------------------------------
module fud_front import fud_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  fud_in_if.sink      in_ch,
  input  q_stat_t     q_stat,
  output logic        push,
  output run_t        push_run
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  logic [1:0] phase_r, phase_nxt, phase;
  logic [7:0] held_r, held_nxt;
  logic       par_r, par_nxt;
  logic       acc;

  logic [7:0] c;
  logic       pl_v, pl_t, pl_esc;
  logic [7:0] pl_b;
  logic       em_v, em_t;
  logic [7:0] em_b;
  logic [1:0] pc;

  assign in_ch.ready = !q_stat.full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign c           = in_ch.in_byte;

  // ordinary byte handling
  always_comb begin
    pl_v   = 1'b1;
    pl_t   = 1'b0;
    pl_esc = 1'b0;
    pl_b   = c;
    if (c == CH_EQ || c == CH_AMP) begin
      pl_t = 1'b1;
      pl_b = 8'h00;
    end else if (c == CH_PLUS) begin
      pl_b = CH_SPACE;
    end else if (c == CH_PCT) begin
      pl_v   = 1'b0;
      pl_esc = 1'b1;
    end
  end

  always_comb begin
    // unused phase code reads as idle
    phase     = (phase_r == PH_PCT || phase_r == PH_DIGIT) ? phase_r : PH_IDLE;
    phase_nxt = PH_IDLE;
    held_nxt  = held_r;
    par_nxt   = par_r;
    pc        = 2'd0;
    em_v      = pl_v;
    em_t      = pl_t;
    em_b      = pl_b;
    if (in_ch.end_of_string) begin
      pc       = phase;
      em_v     = 1'b1;
      em_t     = 1'b1;
      em_b     = 8'h00;
      par_nxt  = 1'b0;
      held_nxt = 8'h00;
    end else begin
      case (phase)
        PH_PCT: begin
          if (is_hex(c)) begin
            held_nxt  = c;
            phase_nxt = PH_DIGIT;
            em_v      = 1'b0;
            em_t      = 1'b0;
          end else begin
            pc = 2'd1;
          end
        end
        PH_DIGIT: begin
          held_nxt = 8'h00;
          if (is_hex(c) && is_hex(held_r)) begin
            em_v = 1'b1;
            em_t = 1'b0;
            em_b = {hex_nib(held_r), hex_nib(c)};
          end else begin
            pc = 2'd2;
          end
        end
        default: begin
          pc = 2'd0;
        end
      endcase
      // plain byte path taken: may open an escape or end a token
      if (!(phase == PH_PCT && is_hex(c)) &&
          !(phase == PH_DIGIT && is_hex(c) && is_hex(held_r))) begin
        phase_nxt = pl_esc ? PH_PCT : PH_IDLE;
        par_nxt   = par_r ^ pl_t;
      end
    end
  end

  always_comb begin
    push_run.cnt      = pc + {1'b0, em_v};
    push_run.term     = em_t;
    push_run.is_value = par_r;
    push_run.bytes    = '0;
    case (pc)
      2'd0: begin
        push_run.bytes[0] = em_b;
      end
      2'd1: begin
        push_run.bytes[0] = CH_PCT;
        push_run.bytes[1] = em_b;
      end
      default: begin
        push_run.bytes[0] = CH_PCT;
        push_run.bytes[1] = held_r;
        push_run.bytes[2] = em_b;
      end
    endcase
  end

  assign push = acc && (push_run.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'h00;
      par_r   <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      par_r   <= par_nxt;
    end
  end

endmodule

>>> rtl/fud_queue.sv
// ----------------------------------------------------------------------------
// fud_queue
// Small FIFO of result runs between the front and back parts.
// ----------------------------------------------------------------------------
module fud_queue import fud_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  run_t    push_run,
  input  logic    pop,
  output run_t    head,
  output q_stat_t q_stat
);

  run_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign q_stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head         = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/fud_back.sv
// ----------------------------------------------------------------------------
// fud_back
// Unpacks queued runs into single results, one per cycle while the output
// is ready, into the output register.
// ----------------------------------------------------------------------------
`include "form_urlencoded_decoder_unit_assert.svh"

module fud_back import fud_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  run_t     head,
  input  q_stat_t  q_stat,
  output logic     pop,
  fud_out_if.source out_ch
);

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       token_end_r, is_value_r, last_r;
  logic [1:0] idx_r;
  logic       ld, last;
  logic [7:0] sel_b;

  assign ld   = !q_stat.empty && (!out_valid_r || out_ch.ready);
  assign last = (idx_r == head.cnt - 2'd1);
  assign pop  = ld && last;

  always_comb begin
    case (idx_r)
      2'd0:    sel_b = head.bytes[0];
      2'd1:    sel_b = head.bytes[1];
      default: sel_b = head.bytes[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (ld) begin
        out_valid_r <= 1'b1;
        idx_r       <= last ? 2'd0 : idx_r + 2'd1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_byte_r  <= sel_b;
      token_end_r <= head.term && last;
      is_value_r  <= head.is_value;
      last_r      <= last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.token_end   = token_end_r;
  assign out_ch.is_value    = is_value_r;
  assign out_ch.last_of_run = last_r;

  `FUD_ASSERT_NOW(a_term_is_last, out_valid_r && token_end_r, last_r, "terminator not last of run")
  `FUD_ASSERT_NOW(a_term_zero, out_valid_r && token_end_r, out_byte_r == 8'h00, "terminator carries data")
  `FUD_ASSERT_NOW(a_idx_in_run, !q_stat.empty, idx_r < head.cnt, "run index beyond run length")
  `FUD_ASSERT_NEXT(a_idx_wraps, pop, idx_r == 2'd0, "run index not rewound after pop")

endmodule
